// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands, sampled on clk_i and disabled during rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSRES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csres assertion failed");

// next-cycle implication
`define CSRES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csres assertion failed");

`endif

// ----- src/csres_pkg.sv -----
// ----------------------------------------------------------------------------
// csres_pkg
// Widths, constants and shared types of the cubic stereo resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package csres_pkg;

  localparam int SMP_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = 23;
  localparam int STEP_W     = 23;
  localparam int GAIN_W     = 9;
  localparam int GAIN_FRAC  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;
  localparam int MAX_RUN    = 64;
  localparam int RUN_CNT_W  = $clog2(MAX_RUN);
  localparam int NUM_CH     = 2;
  localparam int LANE_STAGES = 4;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_W'(1024);
  localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(32'h0040_0000);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(65536);
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = GAIN_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_RESAMPLE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = CFG_IDX_W'(1);

  // lane datapath widths
  localparam int COEF_W  = SMP_W + 4;
  localparam int A_W     = SMP_W + 1;
  localparam int F_W     = FRAC_W + 1;
  localparam int P1_W    = COEF_W + F_W;
  localparam int INNER_W = COEF_W + 1;
  localparam int P2_W    = INNER_W + F_W;
  localparam int MID_W   = INNER_W + 1;
  localparam int P3_W    = MID_W + F_W;
  localparam int V_W     = MID_W + 1;
  localparam int SCL_W   = SMP_W + GAIN_W + 1;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

endpackage

`default_nettype wire

// ----- src/csres_lane.sv -----
// ----------------------------------------------------------------------------
// csres_lane
// One channel of the Catmull-Rom interpolator: four registered stages of
// multiply, the last of which clamps and applies the gain.
// ----------------------------------------------------------------------------
`default_nettype none

module csres_lane
  import csres_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     adv_i,
  input  wire logic [FRAC_W-1:0]        frac_i,
  input  wire logic [GAIN_W-1:0]        gain_i,
  input  wire logic signed [SMP_W-1:0]  pm_i,
  input  wire logic signed [SMP_W-1:0]  p0_i,
  input  wire logic signed [SMP_W-1:0]  p1_i,
  input  wire logic signed [SMP_W-1:0]  p2_i,
  output logic signed [SMP_W-1:0]       sample_o
);

  logic signed [COEF_W-1:0]  pmx, p0x, p1x, p2x;
  logic signed [COEF_W-1:0]  coef_b, coef_c;
  logic signed [A_W-1:0]     coef_a;
  logic signed [F_W-1:0]     frac_s;

  logic signed [A_W-1:0]     a1_q, a2_q;
  logic signed [COEF_W-1:0]  b1_q;
  logic signed [SMP_W-1:0]   p01_q, p02_q, p03_q;
  logic signed [F_W-1:0]     f1_q, f2_q;
  logic signed [P1_W-1:0]    prod1_q;
  logic signed [P2_W-1:0]    prod2_q;
  logic signed [P3_W-1:0]    prod3_q;
  logic signed [SCL_W-1:0]   scaled_q;

  logic signed [INNER_W-1:0] inner;
  logic signed [MID_W-1:0]   mid;
  logic signed [V_W-1:0]     v;
  logic signed [SMP_W-1:0]   v_clamped;
  logic signed [SCL_W-1:0]   gain_s;

  always_comb begin
    pmx    = COEF_W'(pm_i);
    p0x    = COEF_W'(p0_i);
    p1x    = COEF_W'(p1_i);
    p2x    = COEF_W'(p2_i);
    frac_s = $signed({1'b0, frac_i});
    coef_a = A_W'(p1_i) - A_W'(pm_i);
    coef_b = (pmx <<< 1) - (p0x <<< 2) - p0x + (p1x <<< 2) - p2x;
    coef_c = (p0x - p1x) + (p0x - p1x) + (p0x - p1x) + p2x - pmx;
  end

  always_comb begin
    inner = INNER_W'(b1_q) + INNER_W'(prod1_q >>> FRAC_W);
    mid   = MID_W'(a2_q) + MID_W'(prod2_q >>> FRAC_W);
    v     = V_W'(p03_q) + V_W'(prod3_q >>> (FRAC_W + 1));
    if (v > V_W'(SMP_MAX)) begin
      v_clamped = SMP_MAX;
    end else if (v < V_W'(SMP_MIN)) begin
      v_clamped = SMP_MIN;
    end else begin
      v_clamped = SMP_W'(v);
    end
    gain_s = $signed({{(SCL_W-GAIN_W){1'b0}}, gain_i});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q     <= coef_a;
      b1_q     <= coef_b;
      p01_q    <= p0_i;
      f1_q     <= frac_s;
      prod1_q  <= P1_W'(coef_c) * P1_W'(frac_s);

      a2_q     <= a1_q;
      p02_q    <= p01_q;
      f2_q     <= f1_q;
      prod2_q  <= P2_W'(inner) * P2_W'(f1_q);

      p03_q    <= p02_q;
      prod3_q  <= P3_W'(mid) * P3_W'(f2_q);

      scaled_q <= SCL_W'(v_clamped) * gain_s;
    end
  end

  assign sample_o = scaled_q[GAIN_FRAC +: SMP_W];

endmodule

`default_nettype wire

// ----- src/csres_ctrl.sv -----
// ----------------------------------------------------------------------------
// csres_ctrl
// Configuration registers, tap window, fill state and the phase sequencer
// that issues one result per advancing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csres_ctrl
  import csres_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [SMP_W-1:0]  left_in_i,
  input  wire logic signed [SMP_W-1:0]  right_in_i,
  input  wire logic                     end_of_stream_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                     adv_i,
  output issue_t                        issue_o,
  output logic [FRAC_W-1:0]             frac_o,
  output logic [GAIN_W-1:0]             gain_o,
  output logic signed [SMP_W-1:0]       pm_o [NUM_CH],
  output logic signed [SMP_W-1:0]       p0_o [NUM_CH],
  output logic signed [SMP_W-1:0]       p1_o [NUM_CH],
  output logic signed [SMP_W-1:0]       p2_o [NUM_CH]
);

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd2;
  localparam logic [1:0] FILL_RUN   = 2'd3;

  logic [STEP_W-1:0]       step_q;
  logic [GAIN_W-1:0]       gain_q;
  logic signed [SMP_W-1:0] tap_oldest_q  [NUM_CH];
  logic signed [SMP_W-1:0] tap_current_q [NUM_CH];
  logic signed [SMP_W-1:0] tap_next_q    [NUM_CH];
  logic signed [SMP_W-1:0] tap_newest_q  [NUM_CH];
  logic signed [SMP_W-1:0] smp           [NUM_CH];
  logic [PHASE_W-1:0]      phase_q;
  logic [1:0]              fill_q;
  logic                    run_q;
  logic [RUN_CNT_W-1:0]    cnt_q;

  logic                    accept;
  logic                    issue_fire;
  logic                    issue_last;
  logic [PHASE_W-1:0]      phase_sub;
  logic [PHASE_W-1:0]      phase_adv;
  logic [STEP_W-1:0]       step_wr;
  logic [GAIN_W-1:0]       gain_wr;

  assign smp[0] = left_in_i;
  assign smp[1] = right_in_i;

  assign accept     = in_valid_i && !run_q;
  assign issue_fire = run_q && adv_i;
  assign phase_sub  = (phase_q >= PHASE_ONE) ? phase_q - PHASE_ONE : '0;
  assign phase_adv  = phase_q + PHASE_W'(step_q);
  assign issue_last = (phase_adv >= PHASE_ONE) || (cnt_q == RUN_CNT_W'(MAX_RUN - 1));

  always_comb begin
    step_wr = STEP_W'(cfg_wdata_i);
    if (step_wr < STEP_MIN) begin
      step_wr = STEP_MIN;
    end else if (step_wr > STEP_MAX) begin
      step_wr = STEP_MAX;
    end
    gain_wr = cfg_wdata_i[GAIN_W-1:0];
    if (gain_wr > GAIN_MAX) begin
      gain_wr = GAIN_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST;
      gain_q <= GAIN_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RESAMPLE_STEP: step_q <= step_wr;
        REG_GAIN:          gain_q <= gain_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tap_oldest_q[ch]  <= '0;
        tap_current_q[ch] <= '0;
        tap_next_q[ch]    <= '0;
        tap_newest_q[ch]  <= '0;
      end
      phase_q <= '0;
      fill_q  <= FILL_EMPTY;
      run_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (accept) begin
      cnt_q <= '0;
      if (end_of_stream_i) begin
        if (fill_q == FILL_TWO) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            tap_newest_q[ch] <= tap_next_q[ch];
          end
          phase_q <= '0;
          run_q   <= 1'b1;
        end
        fill_q <= FILL_EMPTY;
      end else begin
        unique case (fill_q)
          FILL_EMPTY: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              tap_oldest_q[ch]  <= smp[ch];
              tap_current_q[ch] <= smp[ch];
            end
            fill_q <= FILL_ONE;
          end
          FILL_ONE: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              tap_next_q[ch] <= smp[ch];
            end
            fill_q <= FILL_TWO;
          end
          FILL_TWO: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              tap_newest_q[ch] <= smp[ch];
            end
            phase_q <= '0;
            fill_q  <= FILL_RUN;
            run_q   <= 1'b1;
          end
          default: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              tap_oldest_q[ch]  <= tap_current_q[ch];
              tap_current_q[ch] <= tap_next_q[ch];
              tap_next_q[ch]    <= tap_newest_q[ch];
              tap_newest_q[ch]  <= smp[ch];
            end
            phase_q <= phase_sub;
            run_q   <= (phase_sub < PHASE_ONE);
          end
        endcase
      end
    end else if (issue_fire) begin
      phase_q <= phase_adv;
      cnt_q   <= cnt_q + RUN_CNT_W'(1);
      if (issue_last) begin
        run_q <= 1'b0;
      end
    end
  end

  assign in_stall_o    = run_q;
  assign issue_o.valid = run_q;
  assign issue_o.last  = issue_last;
  assign frac_o        = phase_q[FRAC_W-1:0];
  assign gain_o        = gain_q;
  assign pm_o          = tap_oldest_q;
  assign p0_o          = tap_current_q;
  assign p1_o          = tap_next_q;
  assign p2_o          = tap_newest_q;

endmodule

`default_nettype wire

// ----- src/csres_merge.sv -----
// ----------------------------------------------------------------------------
// csres_merge
// Tracks valid and last alongside the lanes and joins both channels into
// the output register; generates the pipeline advance.
// ----------------------------------------------------------------------------
`default_nettype none

module csres_merge
  import csres_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire issue_t                   issue_i,
  input  wire logic signed [SMP_W-1:0]  left_smp_i,
  input  wire logic signed [SMP_W-1:0]  right_smp_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [SMP_W-1:0]       left_out_o,
  output logic signed [SMP_W-1:0]       right_out_o,
  output logic                          last_o
);

  issue_t                  stage_q [LANE_STAGES];
  logic                    out_valid_q;
  logic                    out_last_q;
  logic signed [SMP_W-1:0] left_q;
  logic signed [SMP_W-1:0] right_q;

  assign adv_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LANE_STAGES; s++) begin
        stage_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      stage_q[0] <= issue_i;
      for (int s = 1; s < LANE_STAGES; s++) begin
        stage_q[s] <= stage_q[s-1];
      end
      out_valid_q <= stage_q[LANE_STAGES-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_last_q <= stage_q[LANE_STAGES-1].last;
      left_q     <= left_smp_i;
      right_q    <= right_smp_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign last_o      = out_last_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

`default_nettype wire

// ----- src/cubic_stereo_resampler.sv -----
// ----------------------------------------------------------------------------
// cubic_stereo_resampler
// Catmull-Rom cubic stereo resampler with a 7.16 phase and 1.8 gain.
// ----------------------------------------------------------------------------
// An item is taken while the input is not stalled; a frame that yields n
// results then holds the input stalled while the phase sequencer issues
// them, one result per cycle while the pipeline advances (n is at most 64).
// Each result leaves through two four-stage lane multipliers, one per
// channel, and then the output register. The next frame is taken while
// the last results of a run are still in flight. Output stall, while a
// result waits at the output, holds the whole pipeline and the sequencer.
`default_nettype none

`include "assert_macros.svh"

module cubic_stereo_resampler
  import csres_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [SMP_W-1:0]  left_in_i,
  input  wire logic signed [SMP_W-1:0]  right_in_i,
  input  wire logic                     end_of_stream_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [SMP_W-1:0]       left_out_o,
  output logic signed [SMP_W-1:0]       right_out_o,
  output logic                          last_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata_i
);

  issue_t                  issue;
  logic                    adv;
  logic [FRAC_W-1:0]       frac;
  logic [GAIN_W-1:0]       gain;
  logic signed [SMP_W-1:0] pm [NUM_CH];
  logic signed [SMP_W-1:0] p0 [NUM_CH];
  logic signed [SMP_W-1:0] p1 [NUM_CH];
  logic signed [SMP_W-1:0] p2 [NUM_CH];
  logic signed [SMP_W-1:0] lane_smp [NUM_CH];

  csres_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .left_in_i       (left_in_i),
    .right_in_i      (right_in_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .adv_i           (adv),
    .issue_o         (issue),
    .frac_o          (frac),
    .gain_o          (gain),
    .pm_o            (pm),
    .p0_o            (p0),
    .p1_o            (p1),
    .p2_o            (p2)
  );

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    csres_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .frac_i   (frac),
      .gain_i   (gain),
      .pm_i     (pm[ch]),
      .p0_i     (p0[ch]),
      .p1_i     (p1[ch]),
      .p2_i     (p2[ch]),
      .sample_o (lane_smp[ch])
    );
  end

  csres_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .left_smp_i  (lane_smp[0]),
    .right_smp_i (lane_smp[1]),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .last_o      (last_o)
  );

  `CSRES_ASSERT_IMP(a_run_holds_input, issue.valid, in_stall_o)
  `CSRES_ASSERT_NXT(a_run_waits_on_stall, issue.valid && !adv, issue.valid && $stable(issue.last))
  `CSRES_ASSERT_IMP(a_run_starts_on_item, $rose(in_stall_o), $past(in_valid_i))

endmodule

`default_nettype wire
